/* hdl/mft_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mft_pkg
// Shared constants, codes and types of the motor feedback turn tracker.
// ----------------------------------------------------------------------------
package mft_pkg;

   // sizing of the tracker
   localparam int COUNTS_PER_TURN = 8192;
   localparam int NUM_SLOTS       = 6;
   localparam int NUM_ID_REGS     = 6;
   localparam int ID_REGS_HELD    = (NUM_SLOTS > NUM_ID_REGS) ? NUM_SLOTS : NUM_ID_REGS;
   localparam int ID_BASE         = 513;

   // field widths
   localparam int MODE_W    = 2;
   localparam int ID_W      = 11;
   localparam int PAYLOAD_W = 56;
   localparam int SLOT_W    = 3;
   localparam int POS_W     = 16;
   localparam int TEMP_W    = 8;
   localparam int DIST_W    = 32;
   localparam int SLOT_IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   // register port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = $clog2(NUM_ID_REGS * 4);
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // request mode codes
   localparam logic [MODE_W-1:0] MODE_FRAME = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

   // clear command covers these slots
   localparam int CLEAR_FIRST = 1;
   localparam int CLEAR_LAST  = 3;

   // classified operation
   typedef enum logic [1:0] {
      OP_NONE,
      OP_FRAME,
      OP_LOAD,
      OP_CLEAR
   } op_type;

   typedef struct packed {
      op_type                    op;
      logic [SLOT_W-1:0]         slot;
      logic [POS_W-1:0]          position;
      logic signed [POS_W-1:0]   speed;
      logic signed [POS_W-1:0]   torque;
      logic [TEMP_W-1:0]         temperature;
      logic signed [DIST_W-1:0]  load_value;
   } cmd_type;

endpackage : mft_pkg
`default_nettype wire

/* hdl/mft_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mft channel interfaces
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mft_req_if import mft_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [MODE_W-1:0]        mode;
   logic [ID_W-1:0]          frame_id;
   logic [PAYLOAD_W-1:0]     payload;
   logic [SLOT_W-1:0]        load_slot;
   logic signed [DIST_W-1:0] load_value;

   modport source (output valid, mode, frame_id, payload, load_slot, load_value,
                   input ready);
   modport sink   (input valid, mode, frame_id, payload, load_slot, load_value,
                   output ready);
endinterface : mft_req_if

interface mft_rsp_if import mft_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     matched;
   logic [SLOT_W-1:0]        slot;
   logic [POS_W-1:0]         position;
   logic signed [POS_W-1:0]  speed;
   logic signed [POS_W-1:0]  torque;
   logic [TEMP_W-1:0]        temperature;
   logic signed [DIST_W-1:0] distance;

   modport source (output valid, matched, slot, position, speed, torque, temperature,
                   distance, input ready);
   modport sink   (input valid, matched, slot, position, speed, torque, temperature,
                   distance, output ready);
endinterface : mft_rsp_if
`default_nettype wire

/* hdl/motor_feedback_turn_tracker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// motor_feedback_turn_tracker
// Multi-turn distance tracking of several motors from their feedback frames.
// ----------------------------------------------------------------------------
//  port    dir   kind             beat contents
//  req     in    valid/ready      mode, frame_id, payload, load_slot, load_value
//  rsp     out   valid/ready      matched, slot, position, speed, torque,
//                                 temperature, distance
//  csr_*   inout apb-style port   slot identifiers, register i at byte 4*i
//
//  one beat per cycle sustained while rsp is not held off; a response passes
//  through the command queue and then the response register
//  synchronous reset restores identifiers 513 upward and clears all slot state
//  req.ready drops only while the two-entry command queue is full, which
//  happens when rsp is held off
// ----------------------------------------------------------------------------
module motor_feedback_turn_tracker import mft_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   mft_req_if.sink                    req,
   mft_rsp_if.source                  rsp,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   logic [ID_W-1:0] slot_id [ID_REGS_HELD];
   logic            queue_full;
   logic            push_valid;
   cmd_type         push_cmd;
   logic            pop;
   logic            pop_valid;
   cmd_type         pop_cmd;

   // identifier registers
   mft_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .slot_id     (slot_id)
   );

   // front: match and decode
   mft_front u_front (
      .req        (req),
      .slot_id    (slot_id),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_cmd   (push_cmd)
   );

   // decoupling queue
   mft_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd)
   );

   // back: state update and response
   mft_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (pop_valid),
      .cmd       (pop_cmd),
      .cmd_pop   (pop),
      .rsp       (rsp)
   );

endmodule : motor_feedback_turn_tracker
`default_nettype wire

/* hdl/mft_csr.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mft_csr
// Register file of the slot identifiers behind an APB-style port.
// ----------------------------------------------------------------------------
module mft_csr import mft_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   output logic      [ID_W-1:0]       slot_id [ID_REGS_HELD]
);

   logic [ID_W-1:0]      id_ff [ID_REGS_HELD];
   logic [CSR_IDX_W-1:0] reg_idx;
   logic                 wr_en;

   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite
                       && (reg_idx < CSR_IDX_W'(NUM_ID_REGS));

   // identifier registers, writable only inside the register list
   always_ff @(posedge clock) begin
      for (int i = 0; i < ID_REGS_HELD; i++) begin
         if (reset) begin
            id_ff[i] <= ID_W'(ID_BASE + i);
         end else if (wr_en && (reg_idx == CSR_IDX_W'(i))) begin
            id_ff[i] <= csr_pwdata[ID_W-1:0];
         end
      end
   end

   // read mux
   always_comb begin
      csr_prdata = '0;
      for (int i = 0; i < NUM_ID_REGS; i++) begin
         if (reg_idx == CSR_IDX_W'(i)) begin
            csr_prdata = CSR_DATA_W'(id_ff[i]);
         end
      end
   end

   assign slot_id = id_ff;

endmodule : mft_csr
`default_nettype wire

/* hdl/mft_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mft_front
// Accepts request beats, matches frame identifiers and decodes the payload.
// ----------------------------------------------------------------------------
module mft_front import mft_pkg::*; (
   mft_req_if.sink              req,
   input  wire logic [ID_W-1:0] slot_id [ID_REGS_HELD],
   input  wire logic            queue_full,
   output logic                 push_valid,
   output cmd_type              push_cmd
);

   logic                  hit;
   logic [SLOT_W-1:0]     hit_slot;

   assign req.ready  = !queue_full;
   assign push_valid = req.valid && !queue_full;

   // identifier match, lowest slot wins
   always_comb begin
      hit      = 1'b0;
      hit_slot = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (slot_id[i] == req.frame_id) begin
            hit      = 1'b1;
            hit_slot = SLOT_W'(i);
         end
      end
   end

   // classify the beat
   always_comb begin
      push_cmd             = '0;
      push_cmd.op          = OP_NONE;
      push_cmd.position    = req.payload[55:40];
      push_cmd.speed       = req.payload[39:24];
      push_cmd.torque      = req.payload[23:8];
      push_cmd.temperature = req.payload[7:0];
      push_cmd.load_value  = req.load_value;
      unique case (req.mode)
         MODE_FRAME: begin
            if (hit) begin
               push_cmd.op   = OP_FRAME;
               push_cmd.slot = hit_slot;
            end
         end
         MODE_LOAD: begin
            if (int'(req.load_slot) < NUM_SLOTS) begin
               push_cmd.op   = OP_LOAD;
               push_cmd.slot = req.load_slot;
            end
         end
         MODE_CLEAR: begin
            push_cmd.op = OP_CLEAR;
         end
         default: begin
            push_cmd.op = OP_NONE;
         end
      endcase
   end

endmodule : mft_front
`default_nettype wire

/* hdl/mft_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mft_queue
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module mft_queue import mft_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push_valid,
   input  cmd_type      push_cmd,
   output logic         full,
   input  wire logic    pop,
   output logic         pop_valid,
   output cmd_type      pop_cmd
);

   cmd_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push, do_pop;

   assign full      = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_cmd   = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_valid;

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule : mft_queue
`default_nettype wire

/* hdl/mft_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mft_back
// Applies commands to the per-slot state and registers the response beat.
// ----------------------------------------------------------------------------
module mft_back import mft_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    cmd_valid,
   input  cmd_type      cmd,
   output logic         cmd_pop,
   mft_rsp_if.source    rsp
);

   localparam logic signed [17:0] TURN = 18'(COUNTS_PER_TURN);
   localparam logic signed [17:0] HALF = 18'(COUNTS_PER_TURN / 2);

   logic [POS_W-1:0]          last_pos_ff [NUM_SLOTS];
   logic signed [DIST_W-1:0]  dist_ff     [NUM_SLOTS];
   logic [NUM_SLOTS-1:0]      seen_ff;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      matched_ff, matched_in;
   logic [SLOT_W-1:0]         slot_ff, slot_in;
   logic [POS_W-1:0]          position_ff, position_in;
   logic signed [POS_W-1:0]   speed_ff, speed_in;
   logic signed [POS_W-1:0]   torque_ff, torque_in;
   logic [TEMP_W-1:0]         temperature_ff, temperature_in;
   logic signed [DIST_W-1:0]  distance_ff, distance_in;

   logic [SLOT_IDX_W-1:0]     idx;
   logic signed [17:0]        diff;
   logic signed [17:0]        step;
   logic signed [DIST_W-1:0]  frame_dist;

   // take a command whenever the output register is free or draining
   assign cmd_pop = cmd_valid && (!rsp_valid_ff || rsp.ready);
   assign idx     = cmd.slot[SLOT_IDX_W-1:0];

   // shortest wrapped step, single correction
   always_comb begin
      diff = 18'(cmd.position) - 18'(last_pos_ff[idx]);
      if (diff > HALF) begin
         step = diff - TURN;
      end else if (diff < -HALF) begin
         step = diff + TURN;
      end else begin
         step = diff;
      end
      frame_dist = seen_ff[idx] ? dist_ff[idx] + DIST_W'(step) : dist_ff[idx];
   end

   // response beat contents
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      matched_in     = matched_ff;
      slot_in        = slot_ff;
      position_in    = position_ff;
      speed_in       = speed_ff;
      torque_in      = torque_ff;
      temperature_in = temperature_ff;
      distance_in    = distance_ff;
      if (cmd_pop) begin
         rsp_valid_in   = 1'b1;
         matched_in     = 1'b0;
         slot_in        = '0;
         position_in    = '0;
         speed_in       = '0;
         torque_in      = '0;
         temperature_in = '0;
         distance_in    = '0;
         unique case (cmd.op)
            OP_FRAME: begin
               matched_in     = 1'b1;
               slot_in        = cmd.slot;
               position_in    = cmd.position;
               speed_in       = cmd.speed;
               torque_in      = cmd.torque;
               temperature_in = cmd.temperature;
               distance_in    = frame_dist;
            end
            OP_LOAD: begin
               matched_in  = 1'b1;
               slot_in     = cmd.slot;
               distance_in = cmd.load_value;
            end
            OP_CLEAR: begin
               matched_in = 1'b1;
            end
            OP_NONE: begin
               matched_in = 1'b0;
            end
         endcase
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      matched_ff     <= matched_in;
      slot_ff        <= slot_in;
      position_ff    <= position_in;
      speed_ff       <= speed_in;
      torque_ff      <= torque_in;
      temperature_ff <= temperature_in;
      distance_ff    <= distance_in;
   end

   // per-slot tracking state
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            last_pos_ff[i] <= '0;
            dist_ff[i]     <= '0;
         end
      end else if (cmd_pop) begin
         unique case (cmd.op)
            OP_FRAME: begin
               last_pos_ff[idx] <= cmd.position;
               dist_ff[idx]     <= frame_dist;
               seen_ff[idx]     <= 1'b1;
            end
            OP_LOAD: begin
               dist_ff[idx] <= cmd.load_value;
            end
            OP_CLEAR: begin
               for (int i = 0; i < NUM_SLOTS; i++) begin
                  if (i >= CLEAR_FIRST && i <= CLEAR_LAST) begin
                     dist_ff[i] <= '0;
                  end
               end
            end
            OP_NONE: begin
               seen_ff <= seen_ff;
            end
         endcase
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.matched     = matched_ff;
   assign rsp.slot        = slot_ff;
   assign rsp.position    = position_ff;
   assign rsp.speed       = speed_ff;
   assign rsp.torque      = torque_ff;
   assign rsp.temperature = temperature_ff;
   assign rsp.distance    = distance_ff;

endmodule : mft_back
`default_nettype wire

/* dv/motor_feedback_turn_tracker_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_feedback_turn_tracker_tb
// Self-checking bench for the turn tracker: a directed burst of edge-case
// beats (wrap boundaries, overflow, loads, clears, misses), then random
// feedback traffic over several identifier settings and idling patterns.
// Every response beat is checked against an in-bench distance predictor.
// ----------------------------------------------------------------------------
module motor_feedback_turn_tracker_tb import mft_pkg::*; ;

   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int CLOCK_HALF   = 4;
   localparam int RESET_CYCLES = 7;
   localparam int ITEMS_PER_PHASE = 150;
   localparam int NUM_PHASES   = 4;
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 200000;

   typedef struct packed {
      logic [MODE_W-1:0]    mode;
      logic [ID_W-1:0]      frame_id;
      logic [PAYLOAD_W-1:0] payload;
      logic [SLOT_W-1:0]    load_slot;
      logic [DIST_W-1:0]    load_value;
   } feedback_req_type;

   typedef struct packed {
      logic              matched;
      logic [SLOT_W-1:0] slot;
      logic [POS_W-1:0]  position;
      logic [POS_W-1:0]  speed;
      logic [POS_W-1:0]  torque;
      logic [TEMP_W-1:0] temperature;
      logic [DIST_W-1:0] distance;
   } feedback_rsp_type;

   // distance predictor and queue of expected response beats
   class turn_scoreboard;
      logic [ID_W-1:0]   id_reg[ID_REGS_HELD];
      logic [POS_W-1:0]  last_pos[NUM_SLOTS];
      logic [DIST_W-1:0] dist_acc[NUM_SLOTS];
      bit                seen[NUM_SLOTS];
      feedback_rsp_type  expected_q[$];
      int                fail_count;

      function new();
         for (int i = 0; i < ID_REGS_HELD; i++) id_reg[i] = ID_W'(ID_BASE + i);
         for (int i = 0; i < NUM_SLOTS; i++) begin
            last_pos[i] = '0;
            dist_acc[i] = '0;
            seen[i]     = 1'b0;
         end
         fail_count = 0;
      endfunction

      function void note_config(int index, logic [ID_W-1:0] value);
         if (index < NUM_ID_REGS) id_reg[index] = value;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // shortest signed step between two raw positions, one correction only
      function logic [DIST_W-1:0] wrapped_step(logic [POS_W-1:0] pos, logic [POS_W-1:0] prev);
         int d;
         d = int'(pos) - int'(prev);
         if (d > COUNTS_PER_TURN / 2) d -= COUNTS_PER_TURN;
         else if (d < -(COUNTS_PER_TURN / 2)) d += COUNTS_PER_TURN;
         return d;
      endfunction

      function void note_request(feedback_req_type b);
         feedback_rsp_type r;
         int hit;
         r   = '0;
         hit = -1;
         case (b.mode)
            MODE_FRAME: begin
               for (int i = 0; i < NUM_SLOTS; i++)
                  if (hit < 0 && id_reg[i] == b.frame_id) hit = i;
               if (hit >= 0) begin
                  r.matched     = 1'b1;
                  r.slot        = SLOT_W'(hit);
                  r.position    = b.payload[55:40];
                  r.speed       = b.payload[39:24];
                  r.torque      = b.payload[23:8];
                  r.temperature = b.payload[7:0];
                  if (seen[hit])
                     dist_acc[hit] += wrapped_step(r.position, last_pos[hit]);
                  last_pos[hit] = r.position;
                  seen[hit]     = 1'b1;
                  r.distance    = dist_acc[hit];
               end
            end
            MODE_LOAD: begin
               if (b.load_slot < NUM_SLOTS) begin
                  dist_acc[b.load_slot] = b.load_value;
                  r.matched  = 1'b1;
                  r.slot     = b.load_slot;
                  r.distance = b.load_value;
               end
            end
            MODE_CLEAR: begin
               for (int i = CLEAR_FIRST; i <= CLEAR_LAST; i++)
                  if (i < NUM_SLOTS) dist_acc[i] = '0;
               r.matched = 1'b1;
            end
            default: ;
         endcase
         expected_q.push_back(r);
      endfunction

      task report_mismatch(string msg);
         fail_count++;
         $display("[%0t] mismatch: %s", $time, msg);
      endtask

      task compare_field(string name, logic [63:0] got, logic [63:0] want);
         if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
      endtask

      task check_response(feedback_rsp_type got);
         feedback_rsp_type want;
         if (expected_q.size() == 0) begin
            report_mismatch("response beat with nothing expected");
         end else begin
            want = expected_q.pop_front();
            compare_field("matched", 64'(got.matched), 64'(want.matched));
            compare_field("slot", 64'(got.slot), 64'(want.slot));
            compare_field("position", 64'(got.position), 64'(want.position));
            compare_field("speed", 64'(got.speed), 64'(want.speed));
            compare_field("torque", 64'(got.torque), 64'(want.torque));
            compare_field("temperature", 64'(got.temperature), 64'(want.temperature));
            compare_field("distance", 64'(got.distance), 64'(want.distance));
         end
      endtask
   endclass

   logic clock;
   logic reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int sender_idle_pct;
   int receiver_stall_pct;
   int cycle_count;

   turn_scoreboard sb;

   mft_req_if req_ch ();
   mft_rsp_if rsp_ch ();

   motor_feedback_turn_tracker dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
   end

   // beat monitor: note accepted requests, check accepted responses
   always @(posedge clock) begin
      if (reset === 1'b0) begin
         if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
            sb.note_request('{req_ch.mode, req_ch.frame_id, req_ch.payload,
                              req_ch.load_slot, req_ch.load_value});
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            sb.check_response('{rsp_ch.matched, rsp_ch.slot, rsp_ch.position,
                                rsp_ch.speed, rsp_ch.torque, rsp_ch.temperature,
                                rsp_ch.distance});
      end
   end

   function automatic feedback_req_type frame_beat(logic [ID_W-1:0] id, logic [15:0] pos,
                                                   logic [15:0] spd, logic [15:0] trq,
                                                   logic [7:0] tmp);
      feedback_req_type b;
      b.mode       = MODE_FRAME;
      b.frame_id   = id;
      b.payload    = {pos, spd, trq, tmp};
      b.load_slot  = SLOT_W'($urandom);
      b.load_value = $urandom;
      return b;
   endfunction

   function automatic feedback_req_type command_beat(logic [MODE_W-1:0] mode,
                                                     logic [SLOT_W-1:0] slot,
                                                     logic [DIST_W-1:0] value);
      feedback_req_type b;
      b.mode       = mode;
      b.frame_id   = ID_W'($urandom);
      b.payload    = {$urandom, 24'($urandom)};
      b.load_slot  = slot;
      b.load_value = value;
      return b;
   endfunction

   // random beat, mostly frames that often step from a slot's last position
   function automatic feedback_req_type random_beat();
      feedback_req_type b;
      int sel;
      int k;
      int delta;
      int mag;
      logic [15:0] pos;
      logic [DIST_W-1:0] value;
      sel = $urandom_range(0, 99);
      if (sel < 78) begin
         k   = $urandom_range(0, NUM_SLOTS - 1);
         pos = 16'($urandom);
         if ($urandom_range(0, 99) < 75) begin
            case ($urandom_range(0, 3))
               0: begin
                  mag = $urandom_range(0, 600);
                  delta = mag - 300;
               end
               1: begin
                  mag = $urandom_range(4090, 4102);
                  delta = $urandom_range(0, 1) ? mag : -mag;
               end
               2: begin
                  mag = $urandom_range(0, 16384);
                  delta = mag - 8192;
               end
               default: delta = 0;
            endcase
            pos = 16'(int'(sb.last_pos[k]) + delta);
         end
         b = frame_beat($urandom_range(0, 99) < 80 ? sb.id_reg[k] : ID_W'($urandom),
                        pos, 16'($urandom), 16'($urandom), 8'($urandom));
      end else if (sel < 90) begin
         case ($urandom_range(0, 9))
            0: value = 32'h7FFF_FFFF;
            1: value = 32'h8000_0000;
            2: value = 32'h7FFF_F000;
            3: value = 32'h8000_1000;
            default: value = $urandom;
         endcase
         b = command_beat(MODE_LOAD,
                          $urandom_range(0, 99) < 85 ? SLOT_W'($urandom_range(0, NUM_SLOTS - 1))
                                                     : SLOT_W'($urandom),
                          value);
      end else if (sel < 95) begin
         b = command_beat(MODE_CLEAR, SLOT_W'($urandom), $urandom);
      end else begin
         b = command_beat(MODE_UNUSED, SLOT_W'($urandom), $urandom);
      end
      return b;
   endfunction

   // present one request beat and hold it until accepted
   task automatic send_request(feedback_req_type b);
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.mode       <= b.mode;
      req_ch.frame_id   <= b.frame_id;
      req_ch.payload    <= b.payload;
      req_ch.load_slot  <= b.load_slot;
      req_ch.load_value <= b.load_value;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
   endtask

   // register write: setup then access
   task automatic csr_write(int index, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(index * 4);
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (csr_pready !== 1'b1) @(posedge clock);
      sb.note_config(index, ID_W'(value));
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // drop valid and wait until every expected beat has come back
   task automatic wait_for_drain();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // identifier set and idling pattern of each random phase
   task automatic configure_phase(int phase);
      logic [ID_W-1:0] ids[NUM_ID_REGS];
      case (phase)
         1: ids = '{11'd0, 11'd2047, 11'd1024, 11'd2047, 11'd1, 11'd1366};
         3: ids = '{11'd1365, 11'd682, 11'd2046, 11'd3, 11'd682, 11'd0};
         4: for (int i = 0; i < NUM_ID_REGS; i++) ids[i] = ID_W'(ID_BASE + i);
         default: for (int i = 0; i < NUM_ID_REGS; i++) ids[i] = ID_W'($urandom);
      endcase
      // upper data bits carry junk that the register must drop
      for (int i = 0; i < NUM_ID_REGS; i++)
         csr_write(i, {21'($urandom), ids[i]});
      // writes past the register list must be ignored
      if (phase == 2) begin
         csr_write(NUM_ID_REGS, $urandom);
         csr_write((1 << CSR_IDX_W) - 1, $urandom);
      end
      case (phase % 4)
         1: begin sender_idle_pct = 58; receiver_stall_pct = 0;  end
         2: begin sender_idle_pct = 0;  receiver_stall_pct = 58; end
         3: begin sender_idle_pct = 31; receiver_stall_pct = 31; end
         default: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
      endcase
   endtask

   // main sequence
   initial begin
      sb = new();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.mode        = MODE_FRAME;
      req_ch.frame_id    = '0;
      req_ch.payload     = '0;
      req_ch.load_slot   = '0;
      req_ch.load_value  = '0;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: wrap boundaries, distance overflow, loads, clears, misses
      send_request(frame_beat(ID_W'(ID_BASE), 16'h0000, 16'h7FFF, 16'h8000, 8'hFF));
      send_request(frame_beat(ID_W'(ID_BASE), 16'h1000, 16'h8000, 16'h7FFF, 8'h00));
      send_request(frame_beat(ID_W'(ID_BASE), 16'h0000, 16'h0000, 16'hFFFF, 8'h80));
      send_request(frame_beat(ID_W'(ID_BASE), 16'h1001, 16'hFFFF, 16'h0000, 8'h7F));
      send_request(frame_beat(ID_W'(ID_BASE), 16'h0000, 16'h1234, 16'h5678, 8'h9A));
      send_request(frame_beat(ID_W'(ID_BASE), 16'hFFFF, 16'h0001, 16'h0001, 8'h01));
      send_request(frame_beat(ID_W'(ID_BASE), 16'h0000, 16'h0002, 16'h0002, 8'h02));
      send_request(frame_beat(ID_W'(ID_BASE + 5), 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF));
      send_request(frame_beat(11'd0, 16'hABCD, 16'h1111, 16'h2222, 8'h33));
      send_request(frame_beat(11'd2047, 16'h5555, 16'hAAAA, 16'h5555, 8'hAA));
      send_request(command_beat(MODE_LOAD, 3'd2, 32'h7FFF_FFFF));
      send_request(frame_beat(ID_W'(ID_BASE + 2), 16'd100, 16'h0010, 16'h0020, 8'h30));
      send_request(frame_beat(ID_W'(ID_BASE + 2), 16'd200, 16'h0040, 16'h0050, 8'h60));
      send_request(command_beat(MODE_LOAD, 3'd5, 32'h8000_0000));
      send_request(frame_beat(ID_W'(ID_BASE + 5), 16'hFFFE, 16'h0000, 16'h0000, 8'h00));
      send_request(command_beat(MODE_LOAD, 3'd6, 32'h1234_5678));
      send_request(command_beat(MODE_LOAD, 3'd7, 32'hFFFF_FFFF));
      send_request(frame_beat(ID_W'(ID_BASE + 1), 16'h0800, 16'h0100, 16'h0200, 8'h10));
      send_request(frame_beat(ID_W'(ID_BASE + 3), 16'h0900, 16'h0300, 16'h0400, 8'h20));
      send_request(frame_beat(ID_W'(ID_BASE + 4), 16'h0A00, 16'h0500, 16'h0600, 8'h30));
      send_request(frame_beat(ID_W'(ID_BASE + 3), 16'h0B00, 16'h0700, 16'h0800, 8'h40));
      send_request(command_beat(MODE_CLEAR, 3'd0, 32'h0));
      send_request(command_beat(MODE_UNUSED, 3'd3, 32'hDEAD_BEEF));
      send_request(command_beat(MODE_LOAD, 3'd0, 32'h0));
      send_request(frame_beat(ID_W'(ID_BASE + 3), 16'h0C00, 16'h0900, 16'h0A00, 8'h50));

      // random phases over several identifier sets and idling patterns
      for (int phase = 1; phase <= NUM_PHASES; phase++) begin
         wait_for_drain();
         configure_phase(phase);
         for (int n = 0; n < ITEMS_PER_PHASE; n++)
            send_request(random_beat());
      end
      wait_for_drain();

      if (sb.pending() != 0)
         sb.report_mismatch("expected beats left over at the end");
      if (sb.fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule : motor_feedback_turn_tracker_tb

/* sim.f */
hdl/mft_pkg.sv
hdl/mft_if.sv
hdl/mft_csr.sv
hdl/mft_front.sv
hdl/mft_queue.sv
hdl/mft_back.sv
hdl/motor_feedback_turn_tracker.sv
dv/motor_feedback_turn_tracker_tb.sv
